// ----- src/hbd_pkg.sv -----
// hbd_pkg: shared types, constants and check functions for the HDLC byte deframer.
// No dependencies; used by every module under src.
package hbd_pkg;

    localparam int CHECK_BYTES_MAX = 4;
    localparam int COUNT_BITS      = 16;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 16;
    localparam int MAXF_W          = 16;
    localparam int MODE_W          = 2;
    localparam int CHK_W           = 32;
    localparam int TAIL_W          = 8 * CHECK_BYTES_MAX;
    localparam int TAIL_IW         = (CHECK_BYTES_MAX > 1) ? $clog2(CHECK_BYTES_MAX) : 1;
    localparam int KLEN_W          = 3;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 16;

    localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
    localparam logic [BYTE_W-1:0] ESC_XOR   = 8'h20;

    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUM8  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FCS16 = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FCS32 = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME  = 1'd1;

    localparam logic [MAXF_W-1:0] MAXF_RESET = 16'd4096;

    localparam logic [15:0] POLY16 = 16'h8408;
    localparam logic [31:0] POLY32 = 32'hEDB88320;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              payload_valid;
        logic              frame_done;
        logic              frame_status;
        logic [LEN_W-1:0]  payload_length;
    } t_result;

    typedef struct packed {
        logic              init;
        logic              upd;
        logic [MODE_W-1:0] mode;
        logic [BYTE_W-1:0] data;
    } t_chk_ctl;

    function automatic logic [KLEN_W-1:0] chk_len(input logic [MODE_W-1:0] mode);
        int k;
        begin
            k = (mode == MODE_FCS32) ? 4 : int'(mode);
            if (k > CHECK_BYTES_MAX) k = CHECK_BYTES_MAX;
            return KLEN_W'(k);
        end
    endfunction

    function automatic logic [CHK_W-1:0] chk_init(input logic [MODE_W-1:0] mode);
        logic [CHK_W-1:0] v;
        begin
            case (mode)
                MODE_FCS16: v = 32'h0000_FFFF;
                MODE_FCS32: v = 32'hFFFF_FFFF;
                default:    v = '0;
            endcase
            return v;
        end
    endfunction

    function automatic logic [CHK_W-1:0] chk_next(input logic [MODE_W-1:0] mode,
                                                  input logic [CHK_W-1:0]  c,
                                                  input logic [BYTE_W-1:0] b);
        logic [15:0]      c16;
        logic [31:0]      c32;
        logic [CHK_W-1:0] v;
        begin
            c16 = c[15:0] ^ {8'h00, b};
            c32 = c ^ {24'h0, b};
            for (int i = 0; i < 8; i++) begin
                c16 = c16[0] ? ((c16 >> 1) ^ POLY16) : (c16 >> 1);
                c32 = c32[0] ? ((c32 >> 1) ^ POLY32) : (c32 >> 1);
            end
            case (mode)
                MODE_SUM8:  v = {24'h0, c[7:0] + b};
                MODE_FCS16: v = {16'h0, c16};
                MODE_FCS32: v = c32;
                default:    v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- src/hbd_check.sv -----
// hbd_check: running frame check register (8-bit sum, FCS-16, FCS-32).
// Depends on hbd_pkg.
module hbd_check (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hbd_pkg::t_chk_ctl          i_ctl,
    output logic [hbd_pkg::CHK_W-1:0]  o_chk
);

    logic [hbd_pkg::CHK_W-1:0] r_chk;
    logic [hbd_pkg::CHK_W-1:0] n_chk;

    always_comb begin
        n_chk = r_chk;
        if (i_ctl.init) begin
            n_chk = hbd_pkg::chk_init(i_ctl.mode);
        end else if (i_ctl.upd) begin
            n_chk = hbd_pkg::chk_next(i_ctl.mode, r_chk, i_ctl.data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk <= hbd_pkg::chk_init(hbd_pkg::MODE_FCS16);
        end else begin
            r_chk <= n_chk;
        end
    end

    assign o_chk = r_chk;

endmodule

// ----- src/hbd_core.sv -----
// hbd_core: flag hunt, unescape, byte count, check-field delay and closing check.
// Depends on hbd_pkg; drives hbd_check through a t_chk_ctl struct.
module hbd_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [hbd_pkg::BYTE_W-1:0]    i_byte,
    input  logic [hbd_pkg::MODE_W-1:0]    i_cfg_mode,
    input  logic [hbd_pkg::MAXF_W-1:0]    i_cfg_max,
    input  logic [hbd_pkg::CHK_W-1:0]     i_chk,
    output hbd_pkg::t_chk_ctl             o_chk_ctl,
    output logic                          o_res_vld,
    output hbd_pkg::t_result              o_res
);

    logic                                r_hunt;
    logic                                r_esc;
    logic [hbd_pkg::COUNT_BITS-1:0]      r_count;
    logic [hbd_pkg::MODE_W-1:0]          r_mode;
    logic [hbd_pkg::BYTE_W-1:0]          r_tail [hbd_pkg::CHECK_BYTES_MAX];

    logic                                n_hunt;
    logic                                n_esc;
    logic [hbd_pkg::COUNT_BITS-1:0]      n_count;
    logic [hbd_pkg::MODE_W-1:0]          n_mode;
    logic [hbd_pkg::BYTE_W-1:0]          n_tail [hbd_pkg::CHECK_BYTES_MAX];

    logic [hbd_pkg::KLEN_W-1:0]          klen;
    logic [hbd_pkg::BYTE_W-1:0]          byte_x;
    logic [31:0]                         cnt_ext;
    logic [31:0]                         k_ext;
    logic                                full;
    logic [hbd_pkg::TAIL_W-1:0]          tail_rd;
    logic [hbd_pkg::TAIL_W-1:0]          fmask;
    logic [hbd_pkg::CHK_W-1:0]           calc;
    hbd_pkg::t_chk_ctl                   ctl;
    hbd_pkg::t_result                    res;
    logic                                res_vld;

    always_comb begin
        klen    = hbd_pkg::chk_len(r_mode);
        byte_x  = r_esc ? (i_byte ^ hbd_pkg::ESC_XOR) : i_byte;
        cnt_ext = 32'(r_count);
        k_ext   = 32'(klen);
        full    = (cnt_ext >= 32'(i_cfg_max))
               || (cnt_ext >= 32'((64'd1 << hbd_pkg::COUNT_BITS) - 64'd1));
        calc    = (r_mode == hbd_pkg::MODE_SUM8) ? i_chk : ~i_chk;
        for (int i = 0; i < hbd_pkg::CHECK_BYTES_MAX; i++) begin
            tail_rd[8*i +: 8] = r_tail[i];
            fmask[8*i +: 8]   = (i < int'(klen)) ? 8'hFF : 8'h00;
        end

        n_hunt  = r_hunt;
        n_esc   = r_esc;
        n_count = r_count;
        n_mode  = r_mode;
        n_tail  = r_tail;
        res     = '0;
        res_vld = 1'b0;
        ctl     = '0;
        ctl.mode = r_mode;
        ctl.data = r_tail[0];

        if (i_fire) begin
            if (r_hunt) begin
                if (i_byte == hbd_pkg::FLAG_BYTE) begin
                    n_hunt   = 1'b0;
                    n_esc    = 1'b0;
                    n_count  = '0;
                    n_mode   = i_cfg_mode;
                    ctl.init = 1'b1;
                    ctl.mode = i_cfg_mode;
                    for (int i = 0; i < hbd_pkg::CHECK_BYTES_MAX; i++) begin
                        n_tail[i] = '0;
                    end
                end
            end else if (i_byte == hbd_pkg::FLAG_BYTE) begin
                n_esc = 1'b0;
                if (r_count != '0) begin
                    n_hunt           = 1'b1;
                    res_vld          = 1'b1;
                    res.frame_done   = 1'b1;
                    if (cnt_ext < k_ext) begin
                        res.frame_status = 1'b1;
                    end else begin
                        res.payload_length = hbd_pkg::LEN_W'(cnt_ext - k_ext);
                        res.frame_status   =
                            (((calc[hbd_pkg::TAIL_W-1:0] ^ tail_rd) & fmask) != '0);
                    end
                end
            end else if (i_byte == hbd_pkg::ESC_BYTE) begin
                n_esc = 1'b1;
            end else if (!full) begin
                n_esc   = 1'b0;
                n_count = r_count + hbd_pkg::COUNT_BITS'(1);
                if (klen == '0) begin
                    res_vld           = 1'b1;
                    res.payload_byte  = byte_x;
                    res.payload_valid = 1'b1;
                end else if (cnt_ext < k_ext) begin
                    n_tail[r_count[hbd_pkg::TAIL_IW-1:0]] = byte_x;
                end else begin
                    for (int i = 0; i < hbd_pkg::CHECK_BYTES_MAX; i++) begin
                        if (i + 1 < int'(klen)) begin
                            n_tail[i] = r_tail[i + 1];
                        end else if (i + 1 == int'(klen)) begin
                            n_tail[i] = byte_x;
                        end
                    end
                    ctl.upd           = 1'b1;
                    res_vld           = 1'b1;
                    res.payload_byte  = r_tail[0];
                    res.payload_valid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunt  <= 1'b1;
            r_esc   <= 1'b0;
            r_count <= '0;
            r_mode  <= hbd_pkg::MODE_FCS16;
        end else begin
            r_hunt  <= n_hunt;
            r_esc   <= n_esc;
            r_count <= n_count;
            r_mode  <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tail <= n_tail;
    end

    assign o_chk_ctl = ctl;
    assign o_res_vld = res_vld;
    assign o_res     = res;

`ifndef SYNTHESIS
    a_res_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_vld |-> (res.payload_valid != res.frame_done))
        else $error("result is neither or both of payload and frame end");

    a_done_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_vld && res.frame_done) |=> r_hunt)
        else $error("closing flag did not return to hunt");

    a_no_res_hunting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hunt |-> !res_vld)
        else $error("result while hunting");

    a_open_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hunt && !n_hunt) |=> (r_count == '0 && !r_esc))
        else $error("frame opened with stale count or escape");
`endif

endmodule

// ----- src/hbd_obuf.sv -----
// hbd_obuf: output register with one skid entry for the result channel.
// Depends on hbd_pkg (t_result).
module hbd_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hbd_pkg::t_result  i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output hbd_pkg::t_result  o_data
);

    logic             r_vld;
    logic             r_skd_vld;
    hbd_pkg::t_result r_dat;
    hbd_pkg::t_result r_skd;

    logic             n_vld;
    logic             n_skd_vld;
    hbd_pkg::t_result n_dat;
    hbd_pkg::t_result n_skd;
    logic             take;

    always_comb begin
        take      = r_vld && !i_stall;
        n_vld     = r_vld;
        n_skd_vld = r_skd_vld;
        n_dat     = r_dat;
        n_skd     = r_skd;
        if (r_skd_vld) begin
            if (take) begin
                n_dat     = r_skd;
                n_skd_vld = 1'b0;
            end
        end else if (i_push) begin
            if (!r_vld || take) begin
                n_dat = i_data;
                n_vld = 1'b1;
            end else begin
                n_skd     = i_data;
                n_skd_vld = 1'b1;
            end
        end else if (take) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_skd_vld <= 1'b0;
        end else begin
            r_vld     <= n_vld;
            r_skd_vld <= n_skd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dat <= n_dat;
        r_skd <= n_skd;
    end

    assign o_full  = r_skd_vld;
    assign o_valid = r_vld;
    assign o_data  = r_dat;

endmodule

// ----- src/hdlc_byte_deframer_fcs_check.sv -----
// hdlc_byte_deframer_fcs_check: top level, configuration registers and wiring.
// Depends on hbd_pkg, hbd_check, hbd_core, hbd_obuf.
//
//   channel   direction  handshake                  beat
//   input     in         i_in_valid / o_in_stall    i_rx_byte
//   output    out        o_out_valid / i_out_stall  o_payload_*, o_frame_*
//   config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One input beat per cycle unless stalled; any result is registered in hbd_obuf.
// Framing, unescape and check update run in the same cycle as acceptance.
// Output register plus one skid entry: input stalls only when both are full.
// Synchronous active-low reset: hunting, check mode FCS-16, capacity 4096.
module hdlc_byte_deframer_fcs_check (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [hbd_pkg::BYTE_W-1:0]       i_rx_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [hbd_pkg::BYTE_W-1:0]       o_payload_byte,
    output logic                             o_payload_valid,
    output logic                             o_frame_done,
    output logic                             o_frame_status,
    output logic [hbd_pkg::LEN_W-1:0]        o_payload_length,
    input  logic                             i_cfg_we,
    input  logic [hbd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [hbd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [hbd_pkg::MODE_W-1:0] r_cfg_mode;
    logic [hbd_pkg::MAXF_W-1:0] r_cfg_max;
    logic                       fire;
    logic                       obuf_full;
    logic                       res_vld;
    hbd_pkg::t_result           res;
    hbd_pkg::t_result           out_dat;
    hbd_pkg::t_chk_ctl          chk_ctl;
    logic [hbd_pkg::CHK_W-1:0]  chk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode <= hbd_pkg::MODE_FCS16;
            r_cfg_max  <= hbd_pkg::MAXF_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hbd_pkg::CFG_CHECK_MODE: r_cfg_mode <= i_cfg_data[hbd_pkg::MODE_W-1:0];
                hbd_pkg::CFG_MAX_FRAME:  r_cfg_max  <= i_cfg_data[hbd_pkg::MAXF_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = obuf_full;
    assign fire       = i_in_valid && !obuf_full;

    hbd_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (chk_ctl),
        .o_chk   (chk)
    );

    hbd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_byte     (i_rx_byte),
        .i_cfg_mode (r_cfg_mode),
        .i_cfg_max  (r_cfg_max),
        .i_chk      (chk),
        .o_chk_ctl  (chk_ctl),
        .o_res_vld  (res_vld),
        .o_res      (res)
    );

    hbd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_vld),
        .i_data  (res),
        .o_full  (obuf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_dat)
    );

    assign o_payload_byte   = out_dat.payload_byte;
    assign o_payload_valid  = out_dat.payload_valid;
    assign o_frame_done     = out_dat.frame_done;
    assign o_frame_status   = out_dat.frame_status;
    assign o_payload_length = out_dat.payload_length;

endmodule
